FILE: hw/rtl/stuffed_frame_decoder_checker_unit_assert.svh
`ifndef STUFFED_FRAME_DECODER_CHECKER_UNIT_ASSERT_SVH
`define STUFFED_FRAME_DECODER_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfd check failed");

// next-cycle implication, checked outside reset
`define SFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfd check failed");

`endif

FILE: hw/rtl/sfd_pkg.sv
`timescale 1ns / 1ps
package sfd_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [7:0] FLAG_BYTE   = 8'h2E;
  localparam logic [7:0] ESC_BYTE    = 8'h2D;
  localparam logic [7:0] ESC_FLAG    = 8'hAE;
  localparam logic [7:0] ESC_ESC     = 8'hAD;
  localparam logic [7:0] SUM_OK      = 8'hFF;
  localparam logic [8:0] COUNT_SAT   = 9'd259;
  localparam logic [8:0] COUNT_MAX   = 9'd258;
  localparam logic [7:0] MAX_PAY_RST = 8'hFF;

  localparam logic [1:0] PH_WAIT  = 2'd0;
  localparam logic [1:0] PH_FRAME = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;

  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_START = 3'd1;
  localparam logic [2:0] ERR_STUFF = 3'd2;
  localparam logic [2:0] ERR_STOP  = 3'd3;
  localparam logic [2:0] ERR_SUM   = 3'd4;
  localparam logic [2:0] ERR_LEN   = 3'd5;

  localparam logic [0:0] REG_MAX_PAYLOAD = 1'b0;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_END  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic       frame_end;
    logic [7:0] data_byte;
    logic [2:0] frame_error;
    logic [7:0] payload_length;
    logic       truncated;
  } res_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] running_sum;
    logic [8:0] decoded_count;
    logic [7:0] device_status;
    logic [7:0] length_byte;
    logic [7:0] held_byte;
    logic       escape_pending;
  } frame_state_t;

endpackage

FILE: hw/rtl/sfd_in_if.sv
`timescale 1ns / 1ps
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

FILE: hw/rtl/sfd_out_if.sv
`timescale 1ns / 1ps
interface sfd_out_if;
  logic       valid;
  logic       ready;
  logic       frame_end;
  logic [7:0] data_byte;
  logic [2:0] frame_error;
  logic [7:0] payload_length;
  logic       truncated;

  modport source (output valid, output frame_end, output data_byte, output frame_error,
                  output payload_length, output truncated, input ready);
  modport sink (input valid, input frame_end, input data_byte, input frame_error,
                input payload_length, input truncated, output ready);
endinterface

FILE: hw/rtl/sfd_cfg_regs.sv
`timescale 1ns / 1ps
module sfd_cfg_regs #(
  parameter logic [7:0] MaxPayloadRst = sfd_pkg::MAX_PAY_RST
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sfd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output logic [7:0]                    max_payload
);
  import sfd_pkg::*;

  logic [7:0] max_payload_r;
  logic [7:0] max_payload_nxt;
  logic       wr_en;
  logic [0:0] reg_idx;

  // word index, byte lanes ignored
  assign reg_idx = paddr[CFG_ADDR_W-1 -: 1];
  assign wr_en   = psel && penable && pwrite && (reg_idx == REG_MAX_PAYLOAD);

  always_comb begin
    max_payload_nxt = max_payload_r;
    if (wr_en) begin
      max_payload_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MaxPayloadRst;
    end else begin
      max_payload_r <= max_payload_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_MAX_PAYLOAD) begin
      prdata = {{(CFG_DATA_W-8){1'b0}}, max_payload_r};
    end
  end

  assign pready      = 1'b1;
  assign max_payload = max_payload_r;
endmodule

FILE: hw/rtl/sfd_step.sv
`timescale 1ns / 1ps
module sfd_step (
  input  sfd_pkg::frame_state_t cur,
  input  sfd_pkg::req_t         req,
  input  logic [7:0]            max_payload,
  output sfd_pkg::frame_state_t nxt,
  output logic                  res_vld,
  output sfd_pkg::res_t         res
);
  import sfd_pkg::*;

  logic       take;
  logic [7:0] dec_byte;
  logic       finish;
  logic       err;
  logic [2:0] err_code;
  logic [8:0] idx_m3;
  logic [8:0] len9;
  logic       sum_bad;
  logic       len_bad;
  logic [7:0] len_ok;
  logic       emit_held;

  // classify the request
  always_comb begin
    take     = 1'b0;
    dec_byte = req.rx_byte;
    finish   = 1'b0;
    err      = 1'b0;
    err_code = ERR_OK;
    if (req.req_type == REQ_END) begin
      if (cur.phase == PH_WAIT) begin
        err      = 1'b1;
        err_code = ERR_START;
      end else if (cur.phase == PH_FRAME) begin
        err      = 1'b1;
        err_code = cur.escape_pending ? ERR_STUFF : ERR_STOP;
      end
    end else if (cur.phase == PH_WAIT) begin
      if (req.rx_byte != FLAG_BYTE) begin
        err      = 1'b1;
        err_code = ERR_START;
      end
    end else if (cur.phase == PH_FRAME) begin
      if (cur.escape_pending) begin
        if (req.rx_byte == ESC_FLAG) begin
          take     = 1'b1;
          dec_byte = FLAG_BYTE;
        end else if (req.rx_byte == ESC_ESC) begin
          take     = 1'b1;
          dec_byte = ESC_BYTE;
        end else begin
          err      = 1'b1;
          err_code = ERR_STUFF;
        end
      end else if (req.rx_byte == FLAG_BYTE) begin
        finish = 1'b1;
      end else if (req.rx_byte != ESC_BYTE) begin
        take = 1'b1;
      end
    end
  end

  // payload emit and stop checks
  assign idx_m3    = cur.decoded_count - 9'd3;
  assign emit_held = (cur.decoded_count >= 9'd3) && (idx_m3 < {1'b0, max_payload});
  assign sum_bad   = cur.running_sum != SUM_OK;
  assign len9      = (cur.decoded_count == 9'd2) ? 9'd0 : idx_m3;
  assign len_bad   = (cur.decoded_count > COUNT_MAX) || (cur.decoded_count < 9'd2) ||
                     ((cur.decoded_count != 9'd2) && (len9 != {1'b0, cur.length_byte}));
  assign len_ok    = len9[7:0];

  always_comb begin
    nxt     = cur;
    res_vld = 1'b0;
    res     = '0;
    if (req.req_type == REQ_END) begin
      nxt.phase          = PH_WAIT;
      nxt.escape_pending = 1'b0;
    end else if (cur.phase == PH_WAIT && !err) begin
      nxt.phase          = PH_FRAME;
      nxt.running_sum    = '0;
      nxt.decoded_count  = '0;
      nxt.device_status  = '0;
      nxt.length_byte    = '0;
      nxt.held_byte      = '0;
      nxt.escape_pending = 1'b0;
    end else if (cur.phase == PH_FRAME) begin
      nxt.escape_pending = 1'b0;
      if (!cur.escape_pending && req.rx_byte == ESC_BYTE) begin
        nxt.escape_pending = 1'b1;
      end
    end

    if (err) begin
      res_vld         = 1'b1;
      res.frame_end   = 1'b1;
      res.frame_error = err_code;
      if (req.req_type == REQ_BYTE) begin
        nxt.phase = PH_DONE;
      end
    end

    if (take) begin
      if (emit_held) begin
        res_vld       = 1'b1;
        res.data_byte = cur.held_byte;
      end
      if (cur.decoded_count == 9'd0) begin
        nxt.device_status = dec_byte;
      end
      if (cur.decoded_count == 9'd1) begin
        nxt.length_byte = dec_byte;
      end
      nxt.held_byte   = dec_byte;
      nxt.running_sum = cur.running_sum + dec_byte;
      if (cur.decoded_count < COUNT_SAT) begin
        nxt.decoded_count = cur.decoded_count + 9'd1;
      end
    end

    if (finish) begin
      nxt.phase     = PH_DONE;
      res_vld       = 1'b1;
      res.frame_end = 1'b1;
      if (sum_bad) begin
        res.frame_error = ERR_SUM;
      end else if (len_bad) begin
        res.frame_error = ERR_LEN;
      end else begin
        res.data_byte      = cur.device_status;
        res.payload_length = len_ok;
        res.truncated      = len_ok > max_payload;
      end
    end
  end
endmodule

FILE: hw/rtl/stuffed_frame_decoder_checker_unit.sv
`timescale 1ns / 1ps
// path: an accepted request waits in the input register; the state update then
//   writes its result, if any, into the result register on out_chan once it has room
// throughput: one request per cycle, limited only by the result register being taken
// reset: rst_n synchronous active low; clears the frame state, both stage valids,
//   and sets max_payload to MaxPayloadRst (255 by default)
module stuffed_frame_decoder_checker_unit #(
  parameter logic [7:0] MaxPayloadRst = sfd_pkg::MAX_PAY_RST
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sfd_in_if.sink                         in_chan,
  sfd_out_if.source                      out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sfd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import sfd_pkg::*;

  logic [7:0]   max_payload;
  logic         in_vld_r;
  logic         in_vld_nxt;
  req_t         in_req_r;
  req_t         in_req_nxt;
  logic         out_vld_r;
  logic         out_vld_nxt;
  res_t         out_res_r;
  res_t         out_res_nxt;
  frame_state_t st_r;
  frame_state_t st_nxt;
  frame_state_t step_nxt;
  logic         step_vld;
  res_t         step_res;
  logic         adv;
  logic         in_acc;
  logic         pay_side_clean;

  sfd_cfg_regs #(
    .MaxPayloadRst(MaxPayloadRst)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_payload(max_payload)
  );

  sfd_step u_step (
    .cur        (st_r),
    .req        (in_req_r),
    .max_payload(max_payload),
    .nxt        (step_nxt),
    .res_vld    (step_vld),
    .res        (step_res)
  );

  // the held request moves on once the result register has room
  assign adv           = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || adv;
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    in_req_nxt  = in_req_r;
    st_nxt      = st_r;
    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (adv) begin
      in_vld_nxt = 1'b0;
      st_nxt     = step_nxt;
    end
    if (in_acc) begin
      in_vld_nxt          = 1'b1;
      in_req_nxt.req_type = in_chan.req_type;
      in_req_nxt.rx_byte  = in_chan.rx_byte;
    end
    if (out_vld_r && out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
    if (adv && step_vld) begin
      out_vld_nxt = 1'b1;
      out_res_nxt = step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      st_r      <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_req_r  <= in_req_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_chan.valid          = out_vld_r;
  assign out_chan.frame_end      = out_res_r.frame_end;
  assign out_chan.data_byte      = out_res_r.data_byte;
  assign out_chan.frame_error    = out_res_r.frame_error;
  assign out_chan.payload_length = out_res_r.payload_length;
  assign out_chan.truncated      = out_res_r.truncated;

  assign pay_side_clean = (out_res_r.frame_error == ERR_OK) &&
                          (out_res_r.payload_length == 8'd0) && !out_res_r.truncated;

`include "stuffed_frame_decoder_checker_unit_assert.svh"

  `SFD_ASSERT_NOW(a_payload_clean, out_vld_r && !out_res_r.frame_end, pay_side_clean)
  `SFD_ASSERT_NOW(a_esc_in_frame, st_r.escape_pending, st_r.phase == PH_FRAME)
  `SFD_ASSERT_NOW(a_count_sat, 1'b1, st_r.decoded_count <= COUNT_SAT)
  `SFD_ASSERT_NEXT(a_stall_holds_req, in_vld_r && !adv, in_vld_r && $stable(in_req_r))
endmodule
